>>> rtl/mtkd_pkg.sv
// mtkd_pkg: constants and helper functions for the keystream byte decipher
// standalone, no dependencies; imported by mt19937_keystream_byte_decipher
package mtkd_pkg;

  localparam int unsigned MtAddrW = 10;

  localparam logic [MtAddrW-1:0] MtWords   = MtAddrW'(624);
  localparam logic [MtAddrW-1:0] MtLast    = MtAddrW'(623);
  localparam logic [MtAddrW-1:0] MtShift   = MtAddrW'(397);
  // far index wraps once the current index reaches this point
  localparam logic [MtAddrW-1:0] MtFarWrap = MtAddrW'(624 - 397);

  localparam logic [31:0] MtInitMult = 32'h6C07_8965;
  localparam logic [31:0] MtMatrix   = 32'h9908_B0DF;
  localparam logic [31:0] TemperB    = 32'hFF3A_58AD;
  localparam logic [31:0] TemperC    = 32'hFFFF_DF8C;
  localparam logic [31:0] SeedOffset = 32'd6;

  localparam logic [7:0] KeyStart   = 8'hC5;
  localparam logic [7:0] StepStart  = 8'h83;
  localparam logic [7:0] StepGrowth = 8'h53;

  function automatic logic [31:0] temper(input logic [31:0] y_in);
    logic [31:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y & TemperB) << 7);
    y = y ^ ((y & TemperC) << 15);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] twist(input logic cur_msb, input logic [30:0] nxt_low,
                                        input logic [31:0] far_word);
    logic [31:0] y;
    logic [31:0] v;
    y = {cur_msb, nxt_low};
    v = far_word ^ (y >> 1);
    if (y[0]) begin
      v = v ^ MtMatrix;
    end
    return v;
  endfunction

endpackage

>>> rtl/mt19937_keystream_byte_decipher.sv
// mt19937_keystream_byte_decipher: byte decipher with an MT19937 keystream and rolling key
// depends on mtkd_pkg; generator state held in a 624 x 32 single-write memory
//
// channel  | direction | handshake             | beat contents
// in       | sink      | in_valid_i/in_ready_o | cipher_byte_i, restart_i
// out      | source    | out_valid_o/out_ready_i | plain_byte_o
// cfg      | sink      | cfg_we_i              | cfg_wdata_i (header length)
//
// a byte passes through accept, three reads of the state memory (current,
// next, far word through its one read port) and one twist/temper/write step.
// a restart beat, or the first beat after reset, first seeds all 624 words
// through the one 32x32 multiplier, one word per cycle.
// reset clears control, keys and the header length; the memory is not cleared.
// a stalled output holds the finishing cycle until the result register frees.
module mt19937_keystream_byte_decipher
  import mtkd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  cipher_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  plain_byte_o,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    StIdle,
    StSeed,
    StRdCur,
    StRdNxt,
    StRdFar,
    StCalc
  } state_e;

  state_e             state_q;
  logic [MtAddrW-1:0] seed_idx_q;
  logic [31:0]        prev_q;
  logic [MtAddrW-1:0] pos_q;
  logic [7:0]         key_q;
  logic [7:0]         step_q;
  logic               seeded_q;
  logic [30:0]        hdr_len_q;
  logic [7:0]         cipher_q;
  logic               cur_msb_q;
  logic [30:0]        nxt_low_q;
  logic               out_valid_q;
  logic [7:0]         plain_q;

  logic [31:0]        mem_q [MtWords];
  logic [31:0]        rdata_q;

  logic               in_beat;
  logic               out_free;
  logic [31:0]        mix;
  logic [31:0]        seed_word;
  logic [MtAddrW-1:0] nxt_addr;
  logic [MtAddrW-1:0] far_addr;
  logic [MtAddrW-1:0] raddr;
  logic               mem_we;
  logic [MtAddrW-1:0] waddr;
  logic [31:0]        wdata;
  logic [31:0]        new_word;
  logic [31:0]        ks_word;

  assign in_ready_o   = (state_q == StIdle);
  assign in_beat      = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign plain_byte_o = plain_q;

  // seeding recurrence, one word per cycle
  assign mix = prev_q ^ (prev_q >> 30);
  always_comb begin
    if (seed_idx_q == '0) begin
      seed_word = {1'b0, hdr_len_q} + SeedOffset;
    end else begin
      seed_word = 32'(mix * MtInitMult) + 32'(seed_idx_q);
    end
  end

  assign nxt_addr = (pos_q == MtLast) ? '0 : pos_q + MtAddrW'(1);
  assign far_addr = (pos_q >= MtFarWrap) ? pos_q - MtFarWrap : pos_q + MtShift;

  // lazy twist: words below pos_q are already new, as the full twist expects
  assign new_word = twist(cur_msb_q, nxt_low_q, rdata_q);
  assign ks_word  = temper(new_word);

  // the far word is read again while the finishing cycle waits on the output
  always_comb begin
    unique case (state_q)
      StRdNxt: raddr = nxt_addr;
      StRdFar: raddr = far_addr;
      StCalc:  raddr = far_addr;
      default: raddr = pos_q;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = pos_q;
    wdata  = new_word;
    unique case (state_q)
      StSeed: begin
        mem_we = 1'b1;
        waddr  = seed_idx_q;
        wdata  = seed_word;
      end
      StCalc: begin
        mem_we = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seed_idx_q  <= '0;
      prev_q      <= '0;
      pos_q       <= '0;
      key_q       <= KeyStart;
      step_q      <= StepStart;
      seeded_q    <= 1'b0;
      hdr_len_q   <= '0;
      cipher_q    <= '0;
      cur_msb_q   <= 1'b0;
      nxt_low_q   <= '0;
      out_valid_q <= 1'b0;
      plain_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        hdr_len_q <= cfg_wdata_i;
      end
      // the finishing cycle refills the result register itself
      if (out_valid_q && out_ready_i && state_q != StCalc) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_beat) begin
            cipher_q <= cipher_byte_i;
            if (restart_i || !seeded_q) begin
              state_q    <= StSeed;
              seed_idx_q <= '0;
              pos_q      <= '0;
              key_q      <= KeyStart;
              step_q     <= StepStart;
            end else begin
              state_q <= StRdCur;
            end
          end
        end
        StSeed: begin
          prev_q <= seed_word;
          if (seed_idx_q == MtLast) begin
            seeded_q <= 1'b1;
            state_q  <= StRdCur;
          end else begin
            seed_idx_q <= seed_idx_q + MtAddrW'(1);
          end
        end
        StRdCur: begin
          state_q <= StRdNxt;
        end
        StRdNxt: begin
          cur_msb_q <= rdata_q[31];
          state_q   <= StRdFar;
        end
        StRdFar: begin
          nxt_low_q <= rdata_q[30:0];
          state_q   <= StCalc;
        end
        StCalc: begin
          if (out_free) begin
            plain_q     <= cipher_q ^ ks_word[7:0] ^ key_q;
            out_valid_q <= 1'b1;
            key_q       <= key_q + step_q;
            step_q      <= step_q + StepGrowth;
            pos_q       <= nxt_addr;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

>>> rtl/mtkd_checker.sv
// mtkd_checker: port-level checks for mt19937_keystream_byte_decipher
// sees the top-level ports only; bound to the top level at the end of this file
module mtkd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] plain_byte_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(plain_byte_o))
    else $error("stalled output beat changed");

  // after an input beat the block stays busy while it reads the current and next words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken again too early");

  // a new result only appears out of the busy finishing cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  // no result becomes valid in the cycle after an input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result produced one cycle after input beat");

endmodule

bind mt19937_keystream_byte_decipher mtkd_checker u_mtkd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .plain_byte_o (plain_byte_o)
);

>>> tb/tb.sv
// tb: self-checking bench for mt19937_keystream_byte_decipher
// keeps its own twister state and rolling key to predict each plain byte
// depends only on the rtl top level and its package
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TwWords    = 624;
  localparam int unsigned TwFar      = 397;
  localparam logic [31:0] TwInitMult = 32'h6C07_8965;
  localparam logic [31:0] TwMatrix   = 32'h9908_B0DF;
  localparam logic [31:0] TapMaskB   = 32'hFF3A_58AD;
  localparam logic [31:0] TapMaskC   = 32'hFFFF_DF8C;
  localparam logic [7:0]  KeyInit    = 8'hC5;
  localparam logic [7:0]  StepInit   = 8'h83;
  localparam logic [7:0]  StepAdd    = 8'h53;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCyc  = 12;
  localparam int unsigned CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  cipher_byte_i = 8'h00;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  plain_byte_o;
  logic        cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;

  mt19937_keystream_byte_decipher u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cipher_byte_i(cipher_byte_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .plain_byte_o (plain_byte_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [31:0] twister [TwWords];
  int unsigned word_pos;
  logic [7:0]  add_key;
  logic [7:0]  add_step;
  bit          seeded;
  logic [30:0] header_len;

  logic [7:0]  plain_expect_q[$];
  int unsigned fault_cnt;
  int unsigned hold_req;
  bit          idle_on;
  int unsigned cycles = 0;

  function automatic logic [31:0] tap_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y & TapMaskB) << 7);
    y = y ^ ((y & TapMaskC) << 15);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic void reseed_twister();
    logic [31:0] prev;
    twister[0] = {1'b0, header_len} + 32'd6;
    for (int i = 1; i < TwWords; i++) begin
      prev = twister[i-1];
      twister[i] = TwInitMult * (prev ^ (prev >> 30)) + 32'(i);
    end
    seeded = 1'b1;
  endfunction

  function automatic void regenerate_twister();
    logic [31:0] y;
    logic [31:0] v;
    for (int i = 0; i < TwWords; i++) begin
      y = {twister[i][31], twister[(i + 1) % TwWords][30:0]};
      v = twister[(i + TwFar) % TwWords] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ TwMatrix;
      end
      twister[i] = v;
    end
  endfunction

  function automatic logic [7:0] decipher_byte(input logic [7:0] c, input logic rs);
    logic [31:0] tw;
    logic [7:0]  ks;
    logic [7:0]  p;
    if (rs || !seeded) begin
      reseed_twister();
      word_pos = 0;
      add_key  = KeyInit;
      add_step = StepInit;
    end
    if (word_pos == 0) begin
      regenerate_twister();
    end
    tw = tap_temper(twister[word_pos]);
    ks = tw[7:0];
    p = c ^ ks ^ add_key;
    add_key  = add_key + add_step;
    add_step = add_step + StepAdd;
    word_pos = (word_pos + 1) % TwWords;
    return p;
  endfunction

  task automatic flag_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= 10) begin
      $display("%s", msg);
    end
  endtask

  // entered and left at a falling edge; valid stays up for a following beat
  task automatic send_byte(input logic [7:0] c, input logic rs);
    while (idle_on && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cipher_byte_i <= c;
    restart_i     <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    plain_expect_q.push_back(decipher_byte(c, rs));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (plain_expect_q.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_header_len(input logic [30:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    header_len = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= !(idle_on && $urandom_range(99) < 6);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (plain_expect_q.size() == 0) begin
        flag_fault($sformatf("unexpected beat: plain_byte %02h", plain_byte_o));
      end else begin
        if (plain_byte_o !== plain_expect_q[0]) begin
          flag_fault($sformatf("mismatch: plain_byte expected %02h got %02h",
                               plain_expect_q[0], plain_byte_o));
        end
        void'(plain_expect_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // first beat after reset must seed itself, using the reset header length
  task automatic test_unseeded_start();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    drain_results();
  endtask

  // a write only takes hold at the next reseed; also back-to-back restarts
  task automatic test_header_write();
    write_header_len(31'h7FFF_FFFF);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h7F, 1'b1);
    drain_results();
    write_header_len(31'h0000_0000);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h10, 1'b0);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    hold_req++;
    for (int i = 0; i < 24; i++) begin
      send_byte(8'($urandom()), (i == 0));
    end
    drain_results();
  endtask

  // crosses the regeneration point at byte 624 without a restart
  task automatic test_long_stream();
    write_header_len(31'($urandom()));
    idle_on = 1'b0;
    for (int i = 0; i < 660; i++) begin
      if (i == 300) begin
        idle_on = 1'b1;
      end
      send_byte(8'($urandom()), (i == 0));
    end
    drain_results();
  endtask

  task automatic test_random_restarts();
    logic [30:0] settings [4];
    settings[0] = 31'h0000_0001;
    settings[1] = 31'h7FFF_FFFF;
    settings[2] = 31'($urandom());
    settings[3] = 31'h0000_0000;
    foreach (settings[s]) begin
      write_header_len(settings[s]);
      for (int i = 0; i < 90; i++) begin
        send_byte(8'($urandom()),
                  (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(29) == 0));
      end
      drain_results();
    end
  endtask

  initial begin
    fault_cnt = 0;
    hold_req  = 0;
    idle_on   = 1'b1;
    word_pos  = 0;
    add_key   = KeyInit;
    add_step  = StepInit;
    seeded    = 1'b0;
    header_len = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_unseeded_start();
    test_header_write();
    test_output_backpressure();
    test_long_stream();
    test_random_restarts();

    if (plain_expect_q.size() != 0) begin
      flag_fault($sformatf("%0d expected beats never arrived", plain_expect_q.size()));
    end
    if (fault_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
